>>> hdl/pss_pkg.sv
package pss_pkg;

   // fixed field widths
   localparam int PHASE_W = 32;
   localparam int MOD_W = 16;
   localparam int CNT_CFG_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_INDEX_W = 3;
   localparam int BSRR_W = 32;
   localparam int GATE_W = 5;
   localparam int SAMPLE_W = 15;
   localparam int PINS = 16;
   localparam int PIN_W = 6;
   localparam int CNT_W = 4;

   // parameter defaults
   localparam int CHANNELS_DEF = 5;
   localparam int FIRST_PIN_DEF = 6;
   localparam int SINE_TABLE_BITS_DEF = 10;

   // register defaults after reset
   localparam logic [MOD_W-1:0] MOD_INDEX_RST = 16'd16220;
   localparam logic [CNT_CFG_W-1:0] CHANNELS_USED_RST = 3'd5;
   localparam logic [PHASE_W-1:0] CARRIER_STEP_RST = 32'd8589935;
   localparam logic [PHASE_W-1:0] SINE_STEP_RST = 32'd715828;
   localparam logic [PHASE_W-1:0] CARRIER_SPACING_RST = 32'd858993459;

   // pi/2 in Q2.30
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MOD_INDEX = 3'd0,
      CSR_CHANNELS_USED = 3'd1,
      CSR_CARRIER_STEP = 3'd2,
      CSR_SINE_STEP = 3'd3,
      CSR_CARRIER_SPACING = 3'd4
   } csr_index_type;

   // quarter-wave sine entry k in Q0.15, taylor series to x^11, elaboration only
   function automatic logic [SAMPLE_W-1:0] sine_entry(input int unsigned k,
                                                      input int unsigned tbits);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic signed [63:0] sum;
      logic [63:0] q;
      x = ((64'(k) * 64'd2 + 64'd1) * HALF_PI_Q30) >> (tbits - 1);
      x2 = (x * x) >> 30;
      term = x;
      sum = $signed(x);
      term = ((term * x2) >> 30) / 64'd6;
      sum = sum - $signed(term);
      term = ((term * x2) >> 30) / 64'd20;
      sum = sum + $signed(term);
      term = ((term * x2) >> 30) / 64'd42;
      sum = sum - $signed(term);
      term = ((term * x2) >> 30) / 64'd72;
      sum = sum + $signed(term);
      term = ((term * x2) >> 30) / 64'd110;
      sum = sum - $signed(term);
      if (sum < 0) begin
         sum = 0;
      end
      q = ($unsigned(sum) + 64'd16384) >> 15;
      if (q > 64'd32767) begin
         q = 64'd32767;
      end
      return q[SAMPLE_W-1:0];
   endfunction

endpackage

>>> hdl/pss_if.sv
interface pss_req_if;
   logic valid;
   logic ready;
   logic restart;
   modport source (output valid, output restart, input ready);
   modport sink (input valid, input restart, output ready);
endinterface

interface pss_rsp_if import pss_pkg::*; ();
   logic valid;
   logic ready;
   logic [BSRR_W-1:0] bsrr_word;
   logic [GATE_W-1:0] upper_gates;
   logic [GATE_W-1:0] lower_gates;
   modport source (output valid, output bsrr_word, output upper_gates,
                   output lower_gates, input ready);
   modport sink (input valid, input bsrr_word, input upper_gates,
                 input lower_gates, output ready);
endinterface

>>> hdl/phase_shifted_spwm_generator_top.sv
// two register stages: an accepted request is held in stage one, then in the output register
// throughput: one transaction per cycle unless stalled; a single compare pass per channel
// a stalled result holds in the output register while one more request waits in stage one
// reset (synchronous, active high) clears both phases, the dead-time history and
// all valid flags, and loads the register defaults
module phase_shifted_spwm_generator_top import pss_pkg::*; #(
   parameter int CHANNELS = CHANNELS_DEF,
   parameter int FIRST_PIN = FIRST_PIN_DEF,
   parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   pss_req_if.sink req_if,
   pss_rsp_if.source rsp_if,
   input  logic csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [MOD_W-1:0] mod_index_ff;
   logic [CNT_CFG_W-1:0] channels_used_ff;
   logic [PHASE_W-1:0] carrier_step_ff, sine_step_ff, carrier_spacing_ff;

   logic s1_valid, s1_take;
   logic [SAMPLE_W-1:0] sine_mag;
   logic sine_neg;
   logic [CHANNELS-1:0][PHASE_W-1:0] car_phase;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mod_index_ff <= MOD_INDEX_RST;
         channels_used_ff <= CHANNELS_USED_RST;
         carrier_step_ff <= CARRIER_STEP_RST;
         sine_step_ff <= SINE_STEP_RST;
         carrier_spacing_ff <= CARRIER_SPACING_RST;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_MOD_INDEX: mod_index_ff <= csr_wdata[MOD_W-1:0];
            CSR_CHANNELS_USED: channels_used_ff <= csr_wdata[CNT_CFG_W-1:0];
            CSR_CARRIER_STEP: carrier_step_ff <= csr_wdata[PHASE_W-1:0];
            CSR_SINE_STEP: sine_step_ff <= csr_wdata[PHASE_W-1:0];
            CSR_CARRIER_SPACING: carrier_spacing_ff <= csr_wdata[PHASE_W-1:0];
            default: ;
         endcase
      end
   end

   // phase accumulators and sine lookup
   pss_phase #(
      .CHANNELS(CHANNELS),
      .SINE_TABLE_BITS(SINE_TABLE_BITS)
   ) u_phase (
      .clock(clock),
      .reset(reset),
      .req_if(req_if),
      .carrier_step(carrier_step_ff),
      .sine_step(sine_step_ff),
      .carrier_spacing(carrier_spacing_ff),
      .s1_take(s1_take),
      .s1_valid(s1_valid),
      .sine_mag(sine_mag),
      .sine_neg(sine_neg),
      .car_phase(car_phase)
   );

   // carrier compare, dead time and pin packing
   pss_gate #(
      .CHANNELS(CHANNELS),
      .FIRST_PIN(FIRST_PIN)
   ) u_gate (
      .clock(clock),
      .reset(reset),
      .modulation_index(mod_index_ff),
      .channels_used(channels_used_ff),
      .s1_valid(s1_valid),
      .sine_mag(sine_mag),
      .sine_neg(sine_neg),
      .car_phase(car_phase),
      .s1_take(s1_take),
      .rsp_if(rsp_if)
   );

endmodule

>>> hdl/pss_phase.sv
module pss_phase import pss_pkg::*; #(
   parameter int CHANNELS = CHANNELS_DEF,
   parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   pss_req_if.sink req_if,
   input  logic [PHASE_W-1:0] carrier_step,
   input  logic [PHASE_W-1:0] sine_step,
   input  logic [PHASE_W-1:0] carrier_spacing,
   input  logic s1_take,
   output logic s1_valid,
   output logic [SAMPLE_W-1:0] sine_mag,
   output logic sine_neg,
   output logic [CHANNELS-1:0][PHASE_W-1:0] car_phase
);

   localparam int QUARTER = 2 ** (SINE_TABLE_BITS - 2);
   localparam int K_W = SINE_TABLE_BITS - 2;

   logic accept;
   logic s1_valid_ff, s1_valid_in;
   logic [PHASE_W-1:0] sine_phase_ff, carrier_phase_ff;
   logic [PHASE_W-1:0] sine_now, carrier_now;
   logic [SINE_TABLE_BITS-1:0] idx;
   logic [1:0] quad;
   logic [K_W-1:0] k_sel;
   logic [SAMPLE_W-1:0] quarter_rom [QUARTER];
   logic [SAMPLE_W-1:0] sine_mag_ff;
   logic sine_neg_ff;
   logic [CHANNELS-1:0][PHASE_W-1:0] car_phase_ff, car_phase_in;

   // constant quarter-wave table
   for (genvar k = 0; k < QUARTER; k++) begin : g_rom
      assign quarter_rom[k] = sine_entry(k, SINE_TABLE_BITS);
   end

   // handshake
   assign req_if.ready = !s1_valid_ff || s1_take;
   assign accept = req_if.valid && req_if.ready;
   assign s1_valid_in = accept ? 1'b1 : (s1_take ? 1'b0 : s1_valid_ff);

   // phases seen by this transaction
   assign sine_now = req_if.restart ? '0 : sine_phase_ff;
   assign carrier_now = req_if.restart ? '0 : carrier_phase_ff;

   // table address with quadrant folding
   assign idx = sine_now[PHASE_W-1 -: SINE_TABLE_BITS];
   assign quad = idx[SINE_TABLE_BITS-1 -: 2];
   assign k_sel = quad[0] ? ~idx[K_W-1:0] : idx[K_W-1:0];

   // per-channel carrier phase
   for (genvar i = 0; i < CHANNELS; i++) begin : g_car
      assign car_phase_in[i] = carrier_now + PHASE_W'(PHASE_W'(i) * carrier_spacing);
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         sine_phase_ff <= '0;
         carrier_phase_ff <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (accept) begin
            sine_phase_ff <= sine_now + sine_step;
            carrier_phase_ff <= carrier_now + carrier_step;
         end
      end
   end

   // stage payload, registered table read
   always_ff @(posedge clock) begin
      if (accept) begin
         sine_mag_ff <= quarter_rom[k_sel];
         sine_neg_ff <= quad[1];
         car_phase_ff <= car_phase_in;
      end
   end

   assign s1_valid = s1_valid_ff;
   assign sine_mag = sine_mag_ff;
   assign sine_neg = sine_neg_ff;
   assign car_phase = car_phase_ff;

endmodule

>>> hdl/pss_gate.sv
module pss_gate import pss_pkg::*; #(
   parameter int CHANNELS = CHANNELS_DEF,
   parameter int FIRST_PIN = FIRST_PIN_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic [MOD_W-1:0] modulation_index,
   input  logic [CNT_CFG_W-1:0] channels_used,
   input  logic s1_valid,
   input  logic [SAMPLE_W-1:0] sine_mag,
   input  logic sine_neg,
   input  logic [CHANNELS-1:0][PHASE_W-1:0] car_phase,
   output logic s1_take,
   pss_rsp_if.source rsp_if
);

   logic load;
   logic out_valid_ff, out_valid_in;
   logic [CNT_W-1:0] n_eff;
   logic [PHASE_W-2:0] prod;
   logic [PHASE_W-1:0] scaled_mag;
   logic signed [PHASE_W+1:0] scaled;
   logic signed [PHASE_W+1:0] tri_val [CHANNELS];
   logic [CHANNELS-1:0] active, level, up, lo;
   logic [CHANNELS-1:0] prev_ff, prev_in;
   logic [BSRR_W-1:0] bsrr_ff, bsrr_in;
   logic [GATE_W-1:0] upper_ff, upper_in, lower_ff, lower_in;

   // handshake
   assign s1_take = !out_valid_ff || rsp_if.ready;
   assign load = s1_valid && s1_take;
   assign out_valid_in = s1_take ? s1_valid : out_valid_ff;

   // active channel count, clamped
   assign n_eff = ({1'b0, channels_used} > CNT_W'(CHANNELS)) ? CNT_W'(CHANNELS)
                                                            : {1'b0, channels_used};

   // scaled sine, 2*index*sample
   assign prod = (PHASE_W-1)'(PHASE_W'(modulation_index) * PHASE_W'(sine_mag));
   assign scaled_mag = {prod, 1'b0};
   assign scaled = sine_neg ? -$signed({2'b00, scaled_mag}) : $signed({2'b00, scaled_mag});

   // carrier triangle, compare and dead time per channel
   for (genvar i = 0; i < CHANNELS; i++) begin : g_ch
      assign tri_val[i] = car_phase[i][PHASE_W-1]
         ? $signed(34'h0_C000_0000 - {2'b00, car_phase[i]})
         : $signed({2'b00, car_phase[i]} - 34'h0_4000_0000);
      assign active[i] = CNT_W'(i) < n_eff;
      assign level[i] = scaled > tri_val[i];
      assign up[i] = active[i] && level[i] && prev_ff[i];
      assign lo[i] = active[i] && !level[i] && !prev_ff[i];
      if (i < GATE_W) begin : g_keep
         assign prev_in[i] = active[i] ? level[i] : prev_ff[i];
      end else begin : g_drop
         assign prev_in[i] = 1'b0;
      end
   end

   // set/reset word packing
   always_comb begin
      bsrr_in = '0;
      for (int i = 0; i < CHANNELS; i++) begin
         for (int p = 0; p < PINS; p++) begin
            if (active[i] && (FIRST_PIN + i == p)) begin
               if (up[i]) bsrr_in[p] = 1'b1;
               else bsrr_in[p + PINS] = 1'b1;
            end
            if (active[i] && (PIN_W'(FIRST_PIN) + PIN_W'(n_eff) + PIN_W'(i) == PIN_W'(p))) begin
               if (lo[i]) bsrr_in[p] = 1'b1;
               else bsrr_in[p + PINS] = 1'b1;
            end
         end
      end
   end

   // gate fields, low channels only
   always_comb begin
      upper_in = '0;
      lower_in = '0;
      for (int j = 0; j < GATE_W; j++) begin
         if (j < CHANNELS) begin
            upper_in[j] = up[j];
            lower_in[j] = lo[j];
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         prev_ff <= '0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (load) begin
            prev_ff <= prev_in;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (load) begin
         bsrr_ff <= bsrr_in;
         upper_ff <= upper_in;
         lower_ff <= lower_in;
      end
   end

   assign rsp_if.valid = out_valid_ff;
   assign rsp_if.bsrr_word = bsrr_ff;
   assign rsp_if.upper_gates = upper_ff;
   assign rsp_if.lower_gates = lower_ff;

endmodule

>>> test/tb.sv
module tb;
   import pss_pkg::*;

   localparam int N_CH = CHANNELS_DEF;
   localparam int FIRST = FIRST_PIN_DEF;
   localparam int TBITS = SINE_TABLE_BITS_DEF;
   localparam int QUARTER = 1 << (TBITS - 2);

   typedef struct packed {
      logic [BSRR_W-1:0] bsrr_word;
      logic [GATE_W-1:0] upper_gates;
      logic [GATE_W-1:0] lower_gates;
   } gate_sample_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   pss_req_if req_bus();
   pss_rsp_if rsp_bus();

   phase_shifted_spwm_generator_top u_top (
      .clock(clock),
      .reset(reset),
      .req_if(req_bus),
      .rsp_if(rsp_bus),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // register copies, loaded with the reset defaults
   logic [MOD_W-1:0] cfg_mod_index = MOD_INDEX_RST;
   logic [CNT_CFG_W-1:0] cfg_channels = CHANNELS_USED_RST;
   logic [PHASE_W-1:0] cfg_carrier_step = CARRIER_STEP_RST;
   logic [PHASE_W-1:0] cfg_sine_step = SINE_STEP_RST;
   logic [PHASE_W-1:0] cfg_spacing = CARRIER_SPACING_RST;

   // generator state as the block should hold it
   logic [PHASE_W-1:0] cur_carrier_phase = '0;
   logic [PHASE_W-1:0] cur_sine_phase = '0;
   logic [N_CH-1:0] cur_prev_levels = '0;
   logic [SAMPLE_W-1:0] sine_quarter [QUARTER];

   logic pending_restarts [$];
   gate_sample_type expected_samples [$];
   gate_sample_type monitor_want;

   int send_idle_pct = 0;
   int rsp_idle_pct = 0;
   int hold_left = 0;
   int n_errors = 0;
   int n_accepted = 0;
   int n_checked = 0;
   int n_reg_writes = 0;
   int n_settings = 0;

   // quarter-wave table entry in Q0.15 from a taylor series in Q2.30
   function automatic logic [SAMPLE_W-1:0] taylor_sine_entry(input int unsigned k);
      logic [63:0] ang;
      logic [63:0] ang_sq;
      logic [63:0] term;
      logic [63:0] rounded;
      logic signed [63:0] acc;
      ang = ((64'(k) * 64'd2 + 64'd1) * HALF_PI_Q30) / (64'd2 * 64'(QUARTER));
      ang_sq = (ang * ang) >> 30;
      term = ang;
      acc = $signed(ang);
      for (int n = 1; n <= 5; n++) begin
         term = ((term * ang_sq) >> 30) / 64'((2 * n) * (2 * n + 1));
         if (n % 2 == 1) begin
            acc = acc - $signed(term);
         end else begin
            acc = acc + $signed(term);
         end
      end
      if (acc < 0) begin
         acc = 0;
      end
      rounded = ($unsigned(acc) + 64'd16384) >> 15;
      if (rounded > 64'd32767) begin
         rounded = 64'd32767;
      end
      return rounded[SAMPLE_W-1:0];
   endfunction

   // one tick: compare every active carrier against the scaled sine, apply dead time
   function automatic gate_sample_type next_gate_sample(input logic restart);
      gate_sample_type s;
      logic [TBITS-1:0] idx;
      logic [1:0] quad;
      logic [TBITS-3:0] k;
      logic signed [63:0] sine_val;
      logic signed [63:0] scaled;
      logic signed [63:0] tri_val;
      logic [PHASE_W-1:0] p;
      logic level;
      logic prev;
      logic up;
      logic lo;
      int n;
      int pin_u;
      int pin_l;
      s = '0;
      if (restart) begin
         cur_carrier_phase = '0;
         cur_sine_phase = '0;
      end
      n = (cfg_channels > N_CH) ? N_CH : int'(cfg_channels);

      // sine sample from the quarter table
      idx = cur_sine_phase[PHASE_W-1 -: TBITS];
      quad = idx[TBITS-1 -: 2];
      k = idx[TBITS-3:0];
      if (quad[0]) begin
         k = (TBITS-2)'(QUARTER - 1 - int'(k));
      end
      sine_val = $signed({49'b0, sine_quarter[k]});
      if (quad[1]) begin
         sine_val = -sine_val;
      end
      scaled = 64'sd2 * $signed({48'b0, cfg_mod_index}) * sine_val;

      for (int i = 0; i < n; i++) begin
         p = cur_carrier_phase + 32'(i) * cfg_spacing;
         if (p[31]) begin
            tri_val = 64'shC000_0000 - $signed({32'b0, p});
         end else begin
            tri_val = $signed({32'b0, p}) - 64'sh4000_0000;
         end
         level = scaled > tri_val;
         prev = cur_prev_levels[i];
         up = level & prev;
         lo = ~level & ~prev;
         pin_u = FIRST + i;
         pin_l = FIRST + n + i;
         if (pin_u < PINS) begin
            s.bsrr_word[up ? pin_u : pin_u + PINS] = 1'b1;
         end
         if (pin_l < PINS) begin
            s.bsrr_word[lo ? pin_l : pin_l + PINS] = 1'b1;
         end
         if (i < GATE_W) begin
            s.upper_gates[i] = up;
            s.lower_gates[i] = lo;
         end
         cur_prev_levels[i] = level;
      end

      cur_carrier_phase = cur_carrier_phase + cfg_carrier_step;
      cur_sine_phase = cur_sine_phase + cfg_sine_step;
      return s;
   endfunction

   // clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // request driver: offers queued ticks, predicts each accepted transaction
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            expected_samples.push_back(next_gate_sample(req_bus.restart));
            n_accepted++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (pending_restarts.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_bus.valid <= 1'b1;
               req_bus.restart <= pending_restarts.pop_front();
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // response monitor: checks each transaction, drives ready with random and long stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_samples.size() == 0) begin
               $error("unexpected gate sample: bsrr_word %h upper %b lower %b",
                      rsp_bus.bsrr_word, rsp_bus.upper_gates, rsp_bus.lower_gates);
               n_errors++;
            end else begin
               monitor_want = expected_samples.pop_front();
               if (rsp_bus.bsrr_word !== monitor_want.bsrr_word) begin
                  $error("bsrr_word: expected %h, actual %h",
                         monitor_want.bsrr_word, rsp_bus.bsrr_word);
                  n_errors++;
               end
               if (rsp_bus.upper_gates !== monitor_want.upper_gates) begin
                  $error("upper_gates: expected %b, actual %b",
                         monitor_want.upper_gates, rsp_bus.upper_gates);
                  n_errors++;
               end
               if (rsp_bus.lower_gates !== monitor_want.lower_gates) begin
                  $error("lower_gates: expected %b, actual %b",
                         monitor_want.lower_gates, rsp_bus.lower_gates);
                  n_errors++;
               end
            end
            n_checked++;
            // every so often hold off long enough to back up the pipeline
            if (n_checked % 250 == 0) begin
               hold_left = 50;
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   // wait until every tick is sent and answered, then let the pipeline settle
   task automatic wait_drained();
      do begin
         @(posedge clock);
      end while (pending_restarts.size() != 0 || req_bus.valid || expected_samples.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_MOD_INDEX: cfg_mod_index = value[MOD_W-1:0];
         CSR_CHANNELS_USED: cfg_channels = value[CNT_CFG_W-1:0];
         CSR_CARRIER_STEP: cfg_carrier_step = value;
         CSR_SINE_STEP: cfg_sine_step = value;
         CSR_CARRIER_SPACING: cfg_spacing = value;
         default: ;
      endcase
      n_reg_writes++;
   endtask

   task automatic load_setting(input logic [CSR_DATA_W-1:0] mod_index,
                               input logic [CSR_DATA_W-1:0] channels,
                               input logic [CSR_DATA_W-1:0] carrier_step,
                               input logic [CSR_DATA_W-1:0] sine_step,
                               input logic [CSR_DATA_W-1:0] spacing);
      write_reg(CSR_MOD_INDEX, mod_index);
      write_reg(CSR_CHANNELS_USED, channels);
      write_reg(CSR_CARRIER_STEP, carrier_step);
      write_reg(CSR_SINE_STEP, sine_step);
      write_reg(CSR_CARRIER_SPACING, spacing);
      @(posedge clock);
      csr_we <= 1'b0;
      n_settings++;
   endtask

   task automatic queue_pattern(input logic [7:0] pattern, input int count);
      for (int i = 0; i < count; i++) begin
         pending_restarts.push_back(pattern[i]);
      end
   endtask

   task automatic queue_random(input int count, input int restart_pct);
      for (int i = 0; i < count; i++) begin
         pending_restarts.push_back($urandom_range(99) < restart_pct);
      end
   endtask

   // phase increment: slow sweeps forward and back, or anything at all
   function automatic logic [PHASE_W-1:0] rand_step();
      case ($urandom_range(3))
         0: return $urandom_range(32'h0100_0000);
         1: return 32'hFFFF_FFFF - $urandom_range(32'h0100_0000);
         2: return $urandom_range(1023);
         default: return $urandom;
      endcase
   endfunction

   // stimulus
   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_bus.valid = 1'b0;
      req_bus.restart = 1'b0;
      rsp_bus.ready = 1'b0;
      for (int k = 0; k < QUARTER; k++) begin
         sine_quarter[k] = taylor_sine_entry(k);
      end
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: reset defaults, then register extremes
      queue_pattern(8'b0010_0001, 6);
      wait_drained();
      // full amplitude, too many channels, quarter-turn sine steps, backward carrier
      load_setting(32'h0000_FFFF, 32'd7, 32'hFFFF_FFFF, 32'h4000_0000, 32'h0000_0000);
      queue_pattern(8'b0000_0001, 5);
      wait_drained();
      // no channels at all
      load_setting(32'd0, 32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF);
      queue_pattern(8'b0000_0010, 3);
      wait_drained();
      // single channel, unit index, half-turn carrier steps
      load_setting(32'd16384, 32'd1, 32'h8000_0000, 32'hC000_0000, 32'h3333_3333);
      queue_pattern(8'b0000_1001, 5);

      // random: three idling profiles, several register settings each
      for (int phase = 0; phase < 3; phase++) begin
         for (int s = 0; s < 6; s++) begin
            logic [CSR_DATA_W-1:0] mod_v;
            logic [CSR_DATA_W-1:0] ch_v;
            logic [CSR_DATA_W-1:0] spacing_v;
            wait_drained();
            case (phase)
               0: begin
                  send_idle_pct = 36;
                  rsp_idle_pct = 61;
               end
               1: begin
                  send_idle_pct = 61;
                  rsp_idle_pct = 36;
               end
               default: begin
                  send_idle_pct = 0;
                  rsp_idle_pct = 0;
               end
            endcase
            case ($urandom_range(9))
               0: mod_v = 32'h0000_FFFF;
               1: mod_v = 32'd0;
               default: mod_v = $urandom_range(16'hFFFF);
            endcase
            ch_v = ($urandom_range(3) == 0) ? $urandom_range(7) : $urandom_range(5, 1);
            spacing_v = ($urandom_range(1) == 0) ? $urandom
                                                 : 32'hFFFF_FFFF / (ch_v == 0 ? 1 : ch_v);
            load_setting(mod_v, ch_v, rand_step(), rand_step(), spacing_v);
            queue_random(55, 4);
         end
      end

      wait_drained();
      repeat (6) @(posedge clock);
      $display("checked %0d pwm tick transactions against %0d results",
               n_accepted, n_checked);
      $display("register writes: %0d over %0d settings, with long output stalls",
               n_reg_writes, n_settings);
      if (n_errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // watchdog
   initial begin
      #(12 * 200000);
      $display("Verification failed");
      $finish;
   end

endmodule
